>>> sv/mac_ip_pair_learning_table_assert.svh
// ----------------------------------------------------------------------------
// mac/ip pair learning table assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef MAC_IP_PAIR_LEARNING_TABLE_ASSERT_SVH
`define MAC_IP_PAIR_LEARNING_TABLE_ASSERT_SVH

// same-cycle implication, reset masked
`define MIPL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mipl assertion failed");

// next-cycle implication, reset masked
`define MIPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mipl assertion failed");

`endif

>>> sv/mipl_pkg.sv
// ----------------------------------------------------------------------------
// mipl_pkg
// constants, codes and interface structs of the mac/ip pair learning table
// ----------------------------------------------------------------------------
package mipl_pkg;

    localparam int ENTRIES    = 256;
    localparam int GROUP_SIZE = 16;
    localparam int N_GROUPS   = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int TYPE_W = 16;
    localparam int VER_W  = 4;
    localparam int USED_W = 9;

    localparam logic [TYPE_W-1:0] TYPE_IPV4    = 16'h0800;
    localparam logic [VER_W-1:0]  VERSION_IPV4 = 4'd4;
    localparam logic [MAC_W-1:0]  MAC_ZERO     = '0;
    localparam logic [MAC_W-1:0]  MAC_ONES     = '1;

    typedef enum logic [1:0] {
        STAT_SKIP    = 2'd0,
        STAT_KNOWN   = 2'd1,
        STAT_NEW     = 2'd2,
        STAT_CHANGED = 2'd3
    } status_t;

    typedef struct packed {
        logic             cmp_en;
        logic             shift;
        logic [MAC_W-1:0] key_mac;
        logic [IP_W-1:0]  key_ip;
        logic [CNT_W-1:0] count;
    } chain_ctrl_t;

    typedef struct packed {
        logic hit;
        logic hit_ip;
    } chain_stat_t;

endpackage

>>> sv/mac_ip_pair_learning_table.sv
// ----------------------------------------------------------------------------
// mac_ip_pair_learning_table
// learns (mac, ip) pairs of ipv4 frames into a ring of ENTRIES entries
// ----------------------------------------------------------------------------
// The s_ channel takes one frame header per item; the m_ channel returns one
// result item per header with the source and destination learning status,
// the entry count, the number of entries overwritten and the changed flag.
// Entries sit in a row of cells, newest first; an insert shifts the whole row
// by one and the oldest entry drops off the end once the row is full.
// Each pair is a compare pass over all cells, a registered group reduction
// and a decide/insert step, done for the source pair, then the destination
// pair. s_ready rises and m_valid is set as the result is written to the
// output register. A non-ipv4 item skips both pairs, and a pair whose mac is
// zero or all ones skips the reduction and the decide/insert step.
// A new item is accepted while a finished result still waits in the output
// register; when m_ready stays low the block holds its next result until the
// output register frees up and takes no further item meanwhile.
// A synchronous reset empties the table (entry count zero, changed flag clear).
// ----------------------------------------------------------------------------
module mac_ip_pair_learning_table
    import mipl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [TYPE_W-1:0] s_ethertype,
    input  logic [VER_W-1:0]  s_ip_version,
    input  logic [MAC_W-1:0]  s_src_mac,
    input  logic [MAC_W-1:0]  s_dst_mac,
    input  logic [IP_W-1:0]   s_src_ip,
    input  logic [IP_W-1:0]   s_dst_ip,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_src_status,
    output logic [1:0]        m_dst_status,
    output logic [USED_W-1:0] m_entries_used,
    output logic [1:0]        m_overwritten,
    output logic              m_table_changed
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CMP  = 5'b00010,
        ST_GRP  = 5'b00100,
        ST_DEC  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic             phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             changed_reg, changed_next;
    logic             m_valid_reg, m_valid_next;

    logic [MAC_W-1:0] src_mac_reg, src_mac_next;
    logic [MAC_W-1:0] dst_mac_reg, dst_mac_next;
    logic [IP_W-1:0]  src_ip_reg, src_ip_next;
    logic [IP_W-1:0]  dst_ip_reg, dst_ip_next;
    status_t          src_st_reg, src_st_next;
    status_t          dst_st_reg, dst_st_next;
    logic [1:0]       overw_reg, overw_next;

    logic [1:0]        m_src_reg, m_src_next;
    logic [1:0]        m_dst_reg, m_dst_next;
    logic [USED_W-1:0] m_used_reg, m_used_next;
    logic [1:0]        m_overw_reg, m_overw_next;
    logic              m_changed_reg, m_changed_next;

    logic [MAC_W-1:0] key_mac;
    logic [IP_W-1:0]  key_ip;
    logic             key_skip;
    logic             is_ipv4;
    status_t          dec_status;
    chain_ctrl_t      ctrl;
    chain_stat_t      stat;

    assign key_mac  = phase_reg ? dst_mac_reg : src_mac_reg;
    assign key_ip   = phase_reg ? dst_ip_reg : src_ip_reg;
    assign key_skip = (key_mac == MAC_ZERO) || (key_mac == MAC_ONES);
    assign is_ipv4  = (s_ethertype == TYPE_IPV4) && (s_ip_version == VERSION_IPV4);

    assign dec_status = stat.hit ? (stat.hit_ip ? STAT_KNOWN : STAT_CHANGED) : STAT_NEW;

    assign ctrl.cmp_en  = (state_reg == ST_CMP) && !key_skip;
    assign ctrl.shift   = (state_reg == ST_DEC) && (dec_status != STAT_KNOWN);
    assign ctrl.key_mac = key_mac;
    assign ctrl.key_ip  = key_ip;
    assign ctrl.count   = count_reg;

    mipl_chain u_chain (
        .aclk (aclk),
        .ctrl (ctrl),
        .stat (stat)
    );

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        changed_next   = changed_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        src_mac_next   = src_mac_reg;
        dst_mac_next   = dst_mac_reg;
        src_ip_next    = src_ip_reg;
        dst_ip_next    = dst_ip_reg;
        src_st_next    = src_st_reg;
        dst_st_next    = dst_st_reg;
        overw_next     = overw_reg;
        m_src_next     = m_src_reg;
        m_dst_next     = m_dst_reg;
        m_used_next    = m_used_reg;
        m_overw_next   = m_overw_reg;
        m_changed_next = m_changed_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    src_mac_next = s_src_mac;
                    dst_mac_next = s_dst_mac;
                    src_ip_next  = s_src_ip;
                    dst_ip_next  = s_dst_ip;
                    src_st_next  = STAT_SKIP;
                    dst_st_next  = STAT_SKIP;
                    overw_next   = 2'd0;
                    phase_next   = 1'b0;
                    state_next   = is_ipv4 ? ST_CMP : ST_OUT;
                end
            end
            ST_CMP: begin
                if (!key_skip) begin
                    state_next = ST_GRP;
                end else if (!phase_reg) begin
                    phase_next = 1'b1;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_GRP: begin
                state_next = ST_DEC;
            end
            ST_DEC: begin
                if (phase_reg) begin
                    dst_st_next = dec_status;
                end else begin
                    src_st_next = dec_status;
                end
                if (dec_status != STAT_KNOWN) begin
                    changed_next = 1'b1;
                    if (count_reg == CNT_W'(ENTRIES)) begin
                        overw_next = overw_reg + 2'd1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                if (!phase_reg) begin
                    phase_next = 1'b1;
                    state_next = ST_CMP;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_src_next     = src_st_reg;
                    m_dst_next     = dst_st_reg;
                    m_used_next    = USED_W'(count_reg);
                    m_overw_next   = overw_reg;
                    m_changed_next = changed_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 1'b0;
            count_reg   <= '0;
            changed_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            changed_reg <= changed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_mac_reg   <= src_mac_next;
        dst_mac_reg   <= dst_mac_next;
        src_ip_reg    <= src_ip_next;
        dst_ip_reg    <= dst_ip_next;
        src_st_reg    <= src_st_next;
        dst_st_reg    <= dst_st_next;
        overw_reg     <= overw_next;
        m_src_reg     <= m_src_next;
        m_dst_reg     <= m_dst_next;
        m_used_reg    <= m_used_next;
        m_overw_reg   <= m_overw_next;
        m_changed_reg <= m_changed_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_src_status    = m_src_reg;
    assign m_dst_status    = m_dst_reg;
    assign m_entries_used  = m_used_reg;
    assign m_overwritten   = m_overw_reg;
    assign m_table_changed = m_changed_reg;

endmodule

>>> sv/mipl_cell.sv
// ----------------------------------------------------------------------------
// mipl_cell
// one table entry: holds a pair, compares it to the key, shifts to its neighbor
// ----------------------------------------------------------------------------
module mipl_cell
    import mipl_pkg::*;
(
    input  logic             aclk,
    input  logic             cmp_en,
    input  logic             shift,
    input  logic             valid,
    input  logic [MAC_W-1:0] key_mac,
    input  logic [IP_W-1:0]  key_ip,
    input  logic [MAC_W-1:0] prev_mac,
    input  logic [IP_W-1:0]  prev_ip,
    input  logic             prev_stale,
    input  logic             prev_hit,
    output logic [MAC_W-1:0] mac,
    output logic [IP_W-1:0]  ip,
    output logic             stale,
    output logic             hit,
    output logic             hit_ip
);

    logic [MAC_W-1:0] mac_reg;
    logic [IP_W-1:0]  ip_reg;
    logic             stale_reg;
    logic             hit_reg;
    logic             hit_ip_reg;
    logic             match;

    // older entries of a mac are shadowed once a newer one exists
    assign match = valid && !stale_reg && (mac_reg == key_mac);

    always_ff @(posedge aclk) begin
        if (cmp_en) begin
            hit_reg    <= match;
            hit_ip_reg <= match && (ip_reg == key_ip);
        end
        if (shift) begin
            mac_reg   <= prev_mac;
            ip_reg    <= prev_ip;
            stale_reg <= prev_stale || prev_hit;
        end
    end

    assign mac    = mac_reg;
    assign ip     = ip_reg;
    assign stale  = stale_reg;
    assign hit    = hit_reg;
    assign hit_ip = hit_ip_reg;

endmodule

>>> sv/mipl_chain.sv
// ----------------------------------------------------------------------------
// mipl_chain
// row of entry cells, newest first, with a registered hit reduction
// ----------------------------------------------------------------------------
module mipl_chain
    import mipl_pkg::*;
(
    input  logic        aclk,
    input  chain_ctrl_t ctrl,
    output chain_stat_t stat
);

    logic [MAC_W-1:0] mac_w    [ENTRIES];
    logic [IP_W-1:0]  ip_w     [ENTRIES];
    logic             stale_w  [ENTRIES];
    logic             hit_w    [ENTRIES];
    logic             hit_ip_w [ENTRIES];

    logic             grp_hit_reg    [N_GROUPS];
    logic             grp_hit_ip_reg [N_GROUPS];
    logic             grp_hit_next    [N_GROUPS];
    logic             grp_hit_ip_next [N_GROUPS];

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic [MAC_W-1:0] p_mac;
        logic [IP_W-1:0]  p_ip;
        logic             p_stale;
        logic             p_hit;
        logic             cell_valid;

        if (i == 0) begin : g_head
            assign p_mac   = ctrl.key_mac;
            assign p_ip    = ctrl.key_ip;
            assign p_stale = 1'b0;
            assign p_hit   = 1'b0;
        end else begin : g_body
            assign p_mac   = mac_w[i-1];
            assign p_ip    = ip_w[i-1];
            assign p_stale = stale_w[i-1];
            assign p_hit   = hit_w[i-1];
        end

        assign cell_valid = CNT_W'(i) < ctrl.count;

        mipl_cell u_cell (
            .aclk       (aclk),
            .cmp_en     (ctrl.cmp_en),
            .shift      (ctrl.shift),
            .valid      (cell_valid),
            .key_mac    (ctrl.key_mac),
            .key_ip     (ctrl.key_ip),
            .prev_mac   (p_mac),
            .prev_ip    (p_ip),
            .prev_stale (p_stale),
            .prev_hit   (p_hit),
            .mac        (mac_w[i]),
            .ip         (ip_w[i]),
            .stale      (stale_w[i]),
            .hit        (hit_w[i]),
            .hit_ip     (hit_ip_w[i])
        );
    end

    always_comb begin
        for (int g = 0; g < N_GROUPS; g++) begin
            grp_hit_next[g]    = 1'b0;
            grp_hit_ip_next[g] = 1'b0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < ENTRIES) begin
                    grp_hit_next[g]    = grp_hit_next[g]    | hit_w[g * GROUP_SIZE + k];
                    grp_hit_ip_next[g] = grp_hit_ip_next[g] | hit_ip_w[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < N_GROUPS; g++) begin
            grp_hit_reg[g]    <= grp_hit_next[g];
            grp_hit_ip_reg[g] <= grp_hit_ip_next[g];
        end
    end

    always_comb begin
        stat.hit    = 1'b0;
        stat.hit_ip = 1'b0;
        for (int g = 0; g < N_GROUPS; g++) begin
            stat.hit    = stat.hit    | grp_hit_reg[g];
            stat.hit_ip = stat.hit_ip | grp_hit_ip_reg[g];
        end
    end

endmodule

>>> sv/mipl_checker.sv
// ----------------------------------------------------------------------------
// mipl_checker
// port-level checks of the mac/ip pair learning table, bound to the top level
// ----------------------------------------------------------------------------
`include "mac_ip_pair_learning_table_assert.svh"

module mipl_checker
    import mipl_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [1:0]        m_src_status,
    input logic [1:0]        m_dst_status,
    input logic [USED_W-1:0] m_entries_used,
    input logic [1:0]        m_overwritten,
    input logic              m_table_changed
);

    // stalled result holds its statuses and entry count
    `MIPL_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_src_status) && $stable(m_dst_status) && $stable(m_entries_used))

    // one item at a time
    `MIPL_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    // overwrite only happens on a full table
    `MIPL_ASSERT_NOW(a_overw_full, m_valid && (m_overwritten != 2'd0), m_entries_used == USED_W'(ENTRIES))

    // any insert sets the changed flag
    `MIPL_ASSERT_NOW(a_changed_set, m_valid && (m_src_status == STAT_NEW || m_src_status == STAT_CHANGED || m_dst_status == STAT_NEW || m_dst_status == STAT_CHANGED), m_table_changed)

    // no insert, no overwrite
    `MIPL_ASSERT_NOW(a_skip_no_overw, m_valid && (m_src_status == STAT_SKIP || m_src_status == STAT_KNOWN) && (m_dst_status == STAT_SKIP || m_dst_status == STAT_KNOWN), m_overwritten == 2'd0)

endmodule

bind mac_ip_pair_learning_table mipl_checker u_mipl_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_src_status    (m_src_status),
    .m_dst_status    (m_dst_status),
    .m_entries_used  (m_entries_used),
    .m_overwritten   (m_overwritten),
    .m_table_changed (m_table_changed)
);

>>> dv/tb_mac_ip_pair_learning_table.sv
// ----------------------------------------------------------------------------
// tb_mac_ip_pair_learning_table
// Self-checking testbench for the mac/ip pair learning table. Frame headers go
// in on the s_ channel and are also fed to a local model of the ring. That
// model queues the result expected for each header. Every result item on the
// m_ channel is compared field by field with the oldest queued result. The
// run covers directed corner cases, a full ring wrap, random traffic with idle
// bursts on both sides, a long output stall, sender pauses and full-rate runs.
// ----------------------------------------------------------------------------
module tb_mac_ip_pair_learning_table;
    import mipl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int POOL_SIZE      = 320;
    localparam int SETTLE_CYCLES  = 24;

    localparam logic [TYPE_W-1:0] TYPE_IPV6    = 16'h86dd;
    localparam logic [VER_W-1:0]  VERSION_IPV6 = 4'd6;

    localparam logic [MAC_W-1:0] MAC_A    = 48'h02005e100001;
    localparam logic [MAC_W-1:0] MAC_B    = 48'h02005e100002;
    localparam logic [MAC_W-1:0] MAC_C    = 48'h02005e100003;
    localparam logic [MAC_W-1:0] MAC_D    = 48'h02005e100004;
    localparam logic [MAC_W-1:0] MAC_HIGH = 48'hfffffffffffe;
    localparam logic [MAC_W-1:0] MAC_LOW  = 48'h000000000001;
    localparam logic [MAC_W-1:0] MAC_WRAP = 48'h060000000000;

    typedef struct {
        logic [TYPE_W-1:0] ethertype;
        logic [VER_W-1:0]  ip_version;
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
        logic [IP_W-1:0]   src_ip;
        logic [IP_W-1:0]   dst_ip;
    } frame_t;

    typedef struct {
        status_t           src_status;
        status_t           dst_status;
        logic [USED_W-1:0] entries_used;
        logic [1:0]        overwritten;
        logic              table_changed;
    } verdict_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [TYPE_W-1:0] s_ethertype = '0;
    logic [VER_W-1:0]  s_ip_version = '0;
    logic [MAC_W-1:0]  s_src_mac = '0;
    logic [MAC_W-1:0]  s_dst_mac = '0;
    logic [IP_W-1:0]   s_src_ip = '0;
    logic [IP_W-1:0]   s_dst_ip = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_src_status;
    logic [1:0]        m_dst_status;
    logic [USED_W-1:0] m_entries_used;
    logic [1:0]        m_overwritten;
    logic              m_table_changed;

    // local copy of the learning ring
    logic [MAC_W-1:0] ring_mac [ENTRIES];
    logic [IP_W-1:0]  ring_ip [ENTRIES];
    int               ring_count = 0;
    int               ring_head = 0;
    logic             ring_dirty = 1'b0;

    verdict_t pending_verdicts[$];

    logic [MAC_W-1:0] mac_pool [POOL_SIZE];
    logic [IP_W-1:0]  ip_pool [POOL_SIZE];

    bit traffic_idle = 1'b0;
    int src_calm_left = 0;
    int sink_hold_request = 0;
    int sink_stall_left = 0;
    int sink_calm_left = 0;
    int idle_cycles = 0;

    int failures = 0;
    int frames_sent = 0;
    int results_checked = 0;
    int evictions_total = 0;
    int status_tally [4] = '{0, 0, 0, 0};

    mac_ip_pair_learning_table dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ethertype     (s_ethertype),
        .s_ip_version    (s_ip_version),
        .s_src_mac       (s_src_mac),
        .s_dst_mac       (s_dst_mac),
        .s_src_ip        (s_src_ip),
        .s_dst_ip        (s_dst_ip),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_src_status    (m_src_status),
        .m_dst_status    (m_dst_status),
        .m_entries_used  (m_entries_used),
        .m_overwritten   (m_overwritten),
        .m_table_changed (m_table_changed)
    );

    always #2 aclk = ~aclk;

    function automatic status_t learn_pair(input logic [MAC_W-1:0] mac,
                                           input logic [IP_W-1:0] ip,
                                           inout logic [1:0] evicted);
        status_t st;
        int      k;
        int      idx;
        bit      found;
        st = STAT_NEW;
        found = 1'b0;
        if (mac == MAC_ZERO || mac == MAC_ONES)
            return STAT_SKIP;
        for (k = 0; k < ring_count && !found; k++) begin
            idx = (ring_head + ENTRIES - 1 - k) % ENTRIES;
            if (ring_mac[idx] == mac) begin
                found = 1'b1;
                if (ring_ip[idx] == ip)
                    return STAT_KNOWN;
                st = STAT_CHANGED;
            end
        end
        ring_mac[ring_head] = mac;
        ring_ip[ring_head] = ip;
        ring_head = (ring_head + 1) % ENTRIES;
        if (ring_count < ENTRIES)
            ring_count++;
        else
            evicted++;
        ring_dirty = 1'b1;
        return st;
    endfunction

    function automatic verdict_t predict_verdict(input frame_t f);
        verdict_t   v;
        logic [1:0] evicted;
        evicted = '0;
        v.src_status = STAT_SKIP;
        v.dst_status = STAT_SKIP;
        if (f.ethertype == TYPE_IPV4 && f.ip_version == VERSION_IPV4) begin
            v.src_status = learn_pair(f.src_mac, f.src_ip, evicted);
            v.dst_status = learn_pair(f.dst_mac, f.dst_ip, evicted);
        end
        v.entries_used = ring_count[USED_W-1:0];
        v.overwritten = evicted;
        v.table_changed = ring_dirty;
        status_tally[v.src_status]++;
        status_tally[v.dst_status]++;
        evictions_total += int'(evicted);
        return v;
    endfunction

    function automatic frame_t make_frame(input logic [TYPE_W-1:0] eth,
                                          input logic [VER_W-1:0] ver,
                                          input logic [MAC_W-1:0] smac,
                                          input logic [IP_W-1:0] sip,
                                          input logic [MAC_W-1:0] dmac,
                                          input logic [IP_W-1:0] dip);
        frame_t f;
        f.ethertype = eth;
        f.ip_version = ver;
        f.src_mac = smac;
        f.src_ip = sip;
        f.dst_mac = dmac;
        f.dst_ip = dip;
        return f;
    endfunction

    task automatic pick_pair(output logic [MAC_W-1:0] mac, output logic [IP_W-1:0] ip);
        logic [63:0] wide;
        int          r;
        int          slot;
        r = $urandom_range(0, 99);
        wide = {$urandom(), $urandom()};
        ip = $urandom();
        if (r < 5) begin
            mac = MAC_ZERO;
        end else if (r < 10) begin
            mac = MAC_ONES;
        end else if (r < 18) begin
            mac = wide[MAC_W-1:0];
        end else begin
            slot = $urandom_range(0, POOL_SIZE - 1);
            if ($urandom_range(0, 9) == 0)
                ip_pool[slot] = $urandom();
            mac = mac_pool[slot];
            ip = ip_pool[slot];
        end
    endtask

    task automatic random_frame(output frame_t f);
        int r;
        r = $urandom_range(0, 99);
        f.ethertype = TYPE_IPV4;
        f.ip_version = VERSION_IPV4;
        if (r >= 85 && r < 90) begin
            f.ip_version = VER_W'($urandom_range(0, 15));
        end else if (r >= 90 && r < 94) begin
            f.ethertype = TYPE_W'($urandom_range(0, 65535));
        end else if (r >= 94) begin
            f.ethertype = TYPE_W'($urandom_range(0, 65535));
            f.ip_version = VER_W'($urandom_range(0, 15));
        end
        pick_pair(f.src_mac, f.src_ip);
        pick_pair(f.dst_mac, f.dst_ip);
        if ($urandom_range(0, 9) == 0)
            f.dst_mac = f.src_mac;
    endtask

    task automatic send_frame(input frame_t f);
        int gap;
        gap = 0;
        if (traffic_idle) begin
            if (src_calm_left != 0)
                src_calm_left--;
            else if ($urandom_range(0, 19) == 0)
                src_calm_left = $urandom_range(20, 60);
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 17);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ethertype <= f.ethertype;
        s_ip_version <= f.ip_version;
        s_src_mac <= f.src_mac;
        s_dst_mac <= f.dst_mac;
        s_src_ip <= f.src_ip;
        s_dst_ip <= f.dst_ip;
        do @(posedge aclk); while (!s_ready);
        pending_verdicts.push_back(predict_verdict(f));
        frames_sent++;
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        frame_t f;
        repeat (count) begin
            random_frame(f);
            send_frame(f);
        end
    endtask

    task automatic test_directed_cases();
        send_frame(make_frame(TYPE_IPV6, VERSION_IPV4, MAC_A, 32'h0a000001, MAC_B, 32'h0a000002));
        send_frame(make_frame(TYPE_IPV4, VERSION_IPV6, MAC_A, 32'h0a000001, MAC_B, 32'h0a000002));
        send_frame(make_frame(16'hffff, 4'hf, MAC_ONES, 32'hffffffff, MAC_ONES, 32'hffffffff));
        send_frame(make_frame(16'h0000, 4'h0, MAC_ZERO, 32'h0, MAC_ZERO, 32'h0));
        send_frame(make_frame(TYPE_IPV4, VERSION_IPV4, MAC_ZERO, 32'h0a000001,
                              MAC_ONES, 32'h0a000002));
        send_frame(make_frame(TYPE_IPV4, VERSION_IPV4, MAC_A, 32'h0a000001, MAC_B, 32'h0a000002));
        send_frame(make_frame(TYPE_IPV4, VERSION_IPV4, MAC_A, 32'h0a000001, MAC_B, 32'h0a000002));
        send_frame(make_frame(TYPE_IPV4, VERSION_IPV4, MAC_A, 32'h0a000003, MAC_B, 32'h0a000002));
        send_frame(make_frame(TYPE_IPV4, VERSION_IPV4, MAC_A, 32'h0a000001, MAC_B, 32'h0a000002));
        // same mac on both sides: the destination sees the source insert
        send_frame(make_frame(TYPE_IPV4, VERSION_IPV4, MAC_C, 32'hffffffff, MAC_C, 32'hffffffff));
        send_frame(make_frame(TYPE_IPV4, VERSION_IPV4, MAC_D, 32'h00000000, MAC_D, 32'h00000001));
        send_frame(make_frame(TYPE_IPV4, VERSION_IPV4, MAC_HIGH, 32'h80000000,
                              MAC_LOW, 32'h7fffffff));
        send_frame(make_frame(16'h0801, VERSION_IPV4, MAC_A, 32'h0a000001, MAC_B, 32'h0a000002));
        send_frame(make_frame(TYPE_IPV4, VERSION_IPV4, MAC_B, 32'h0a000002,
                              MAC_ONES, 32'h0a000009));
        send_frame(make_frame(TYPE_IPV4, VERSION_IPV4, MAC_LOW, 32'h7fffffff,
                              MAC_ZERO, 32'h0));
        stop_sending();
        wait_drained();
    endtask

    task automatic test_ring_wrap();
        int n;
        n = 0;
        while (ring_count < ENTRIES || n < 200) begin
            send_frame(make_frame(TYPE_IPV4, VERSION_IPV4, MAC_WRAP + MAC_W'(2 * n), IP_W'(n),
                                  MAC_WRAP + MAC_W'(2 * n + 1), IP_W'(~n)));
            n++;
        end
        // one pair skipped while full
        send_frame(make_frame(TYPE_IPV4, VERSION_IPV4, MAC_ZERO, 32'h0,
                              MAC_WRAP + MAC_W'(2 * n), 32'h1));
        // evicted address comes back as new
        send_frame(make_frame(TYPE_IPV4, VERSION_IPV4, MAC_A, 32'h0a000001, MAC_WRAP, 32'h0));
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        traffic_idle = 1'b1;
        send_random(count);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        bit saved;
        saved = traffic_idle;
        traffic_idle = 1'b0;
        sink_hold_request = LONG_HOLD;
        send_random(10);
        stop_sending();
        wait_drained();
        traffic_idle = saved;
    endtask

    task automatic test_sender_pause();
        repeat (3) begin
            send_random(15);
            stop_sending();
            wait_drained();
        end
    endtask

    task automatic test_full_rate_stream(input int count);
        traffic_idle = 1'b0;
        send_random(count);
        stop_sending();
        wait_drained();
    endtask

    task automatic check_field(input string label, input logic [USED_W-1:0] want,
                               input logic [USED_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, label, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result item with none expected, expected nothing got %0d/%0d",
                         $time, m_src_status, m_dst_status);
                failures++;
            end else begin
                want = pending_verdicts.pop_front();
                check_field("src_status", USED_W'(want.src_status), USED_W'(m_src_status));
                check_field("dst_status", USED_W'(want.dst_status), USED_W'(m_dst_status));
                check_field("entries_used", want.entries_used, m_entries_used);
                check_field("overwritten", USED_W'(want.overwritten), USED_W'(m_overwritten));
                check_field("table_changed", USED_W'(want.table_changed),
                            USED_W'(m_table_changed));
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (sink_hold_request != 0) begin
            sink_stall_left = sink_hold_request;
            sink_hold_request = 0;
        end else if (traffic_idle && sink_stall_left == 0) begin
            if (sink_calm_left != 0)
                sink_calm_left--;
            else if ($urandom_range(0, 31) == 0)
                sink_calm_left = $urandom_range(20, 80);
            else if ($urandom_range(0, 7) == 0)
                sink_stall_left = $urandom_range(1, 17);
        end
        if (!aresetn || sink_stall_left != 0) begin
            m_ready <= 1'b0;
            if (sink_stall_left != 0)
                sink_stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending_verdicts.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            mac_pool[i] = MAC_W'({$urandom(), $urandom()});
            ip_pool[i] = $urandom();
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_ring_wrap();
        test_random_traffic(500);
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic(350);
        test_full_rate_stream(200);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("checked %0d results of %0d headers: %0d new, %0d known, %0d changed, %0d skipped",
                 results_checked, frames_sent, status_tally[STAT_NEW], status_tally[STAT_KNOWN],
                 status_tally[STAT_CHANGED], status_tally[STAT_SKIP]);
        $display("ring wrapped with %0d evictions, long output stall and sender drain pauses run",
                 evictions_total);
        if (failures == 0 && pending_verdicts.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results never arrived", failures,
                     pending_verdicts.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
